### rtl/core/spmv_pkg.sv
// Shared widths, request codes and beat structures for the CSR sparse matrix-vector core.
`default_nettype none
package spmv_pkg;

  localparam int POS_W = 10;
  localparam int VAL_W = 32;
  localparam int ACC_W = 48;
  localparam int CFG_W = 11;
  localparam int PROD_W = 2 * VAL_W;
  localparam int FRAC_BITS = 16;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ENTRY = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic req_type;
    logic pos_ok;
    logic has_entry;
    logic row_end;
  } spmv_ctrl_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] row_sum;
    logic [POS_W-1:0]        row_number;
    logic                    index_error;
    logic                    saturated;
  } spmv_res_t;

endpackage
`default_nettype wire

### rtl/core/spmv_req_if.sv
// Request channel: vector loads and matrix entries.
`default_nettype none
interface spmv_req_if import spmv_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] entry_value;
  logic                    has_entry;
  logic                    row_end;

  modport source (output valid, req_type, position, entry_value, has_entry, row_end,
                  input ready);
  modport sink (input valid, req_type, position, entry_value, has_entry, row_end,
                output ready);
endinterface
`default_nettype wire

### rtl/core/spmv_rsp_if.sv
// Response channel: finished row results.
`default_nettype none
interface spmv_rsp_if import spmv_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] row_sum;
  logic [POS_W-1:0]        row_number;
  logic                    index_error;
  logic                    saturated;

  modport source (output valid, row_sum, row_number, index_error, saturated, input ready);
  modport sink (input valid, row_sum, row_number, index_error, saturated, output ready);
endinterface
`default_nettype wire

### rtl/core/spmv_cfg_if.sv
// Configuration write channel carrying the vector length.
`default_nettype none
interface spmv_cfg_if import spmv_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] vector_length;

  modport source (output valid, vector_length, input ready);
  modport sink (input valid, vector_length, output ready);
endinterface
`default_nettype wire

### rtl/core/csr_sparse_matrix_vector_multiply_core.sv
// Top level: CSR sparse matrix times dense vector, one request beat per cycle unless stalled.
// Path: RAM read and first stage, registered product, then accumulate into the result queue.
// Throughput: one beat per cycle unless stalled, set by the single vector RAM port and the MAC.
// A two-entry result queue keeps req ready while a result waits on rsp.
// Reset (synchronous): clears pipeline, queue, row state; vector length to min(MAX_SIZE, 1024).
// The vector RAM is not cleared; elements are defined once loaded.
`default_nettype none
module csr_sparse_matrix_vector_multiply_core import spmv_pkg::*; #(
  parameter int MAX_SIZE = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  spmv_req_if.sink   req,
  spmv_cfg_if.sink   cfg,
  spmv_rsp_if.source rsp
);

  localparam int AW = $clog2(MAX_SIZE);
  localparam int LIM_W = $clog2(MAX_SIZE + 1);
  localparam int LIM_RST = (MAX_SIZE < 1024) ? MAX_SIZE : 1024;

  logic [LIM_W-1:0]        limit;
  logic                    adv;
  logic                    accept;
  logic                    pos_ok;
  logic                    oq_full;
  logic                    s1_valid;
  spmv_ctrl_t              s1_ctrl;
  logic signed [VAL_W-1:0] s1_value;
  logic signed [VAL_W-1:0] rdata;
  logic                    push;
  spmv_res_t               push_res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIM_W'(LIM_RST);
    end else if (cfg.valid) begin
      if (cfg.vector_length == '0 || 32'(cfg.vector_length) > MAX_SIZE) begin
        limit <= LIM_W'(MAX_SIZE);
      end else begin
        limit <= LIM_W'(cfg.vector_length);
      end
    end
  end

  assign adv       = !oq_full;
  assign req.ready = adv;
  assign accept    = req.valid && adv;
  assign pos_ok    = 32'(req.position) < 32'(limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_ctrl  <= '{req_type: req.req_type, pos_ok: pos_ok, has_entry: req.has_entry,
                    row_end: req.row_end};
      s1_value <= req.entry_value;
    end
  end

  spmv_vstore #(
    .DEPTH(MAX_SIZE),
    .VALUE_BITS(VALUE_BITS)
  ) u_vstore (
    .clk(clk),
    .en(accept),
    .we(accept && req.req_type == REQ_LOAD && pos_ok),
    .addr(AW'(req.position)),
    .wdata(req.entry_value[VALUE_BITS-1:0]),
    .rdata(rdata)
  );

  spmv_mac #(
    .LIM_W(LIM_W)
  ) u_mac (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .s1_valid(s1_valid),
    .s1_ctrl(s1_ctrl),
    .s1_value(s1_value),
    .rdata(rdata),
    .limit(limit),
    .push(push),
    .push_res(push_res)
  );

  spmv_oq u_oq (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_res(push_res),
    .full(oq_full),
    .rsp(rsp)
  );

`ifndef SYNTHESIS
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted beat did not reach first stage");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    !adv |=> s1_valid == $past(s1_valid))
    else $error("first stage changed while stalled");

  a_full_has_valid: assert property (@(posedge clk) disable iff (rst)
    oq_full |-> rsp.valid)
    else $error("result queue full without a valid result");
`endif

endmodule
`default_nettype wire

### rtl/core/spmv_vstore.sv
// Dense vector store: single-port RAM with registered read.
`default_nettype none
module spmv_vstore import spmv_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic                          we,
  input  wire logic [$clog2(DEPTH)-1:0]      addr,
  input  wire logic signed [VALUE_BITS-1:0]  wdata,
  output logic signed [VAL_W-1:0]            rdata
);

  logic signed [VALUE_BITS-1:0] mem [DEPTH];
  logic signed [VALUE_BITS-1:0] rd_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (en) begin
      rd_q <= mem[addr];
    end
  end

  assign rdata = VAL_W'(rd_q);

endmodule
`default_nettype wire

### rtl/core/spmv_mac.sv
// Product stage and saturating row accumulator with row bookkeeping.
`default_nettype none
module spmv_mac import spmv_pkg::*; #(
  parameter int LIM_W = 11
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    adv,
  input  wire logic                    s1_valid,
  input  wire spmv_ctrl_t              s1_ctrl,
  input  wire logic signed [VAL_W-1:0] s1_value,
  input  wire logic signed [VAL_W-1:0] rdata,
  input  wire logic [LIM_W-1:0]        limit,
  output logic                         push,
  output spmv_res_t                    push_res
);

  logic                     s2_valid;
  spmv_ctrl_t               s2_ctrl;
  logic signed [ACC_W-1:0]  s2_prod;
  logic signed [PROD_W-1:0] prod;

  logic signed [ACC_W-1:0]  acc;
  logic [POS_W-1:0]         row;
  logic                     err;
  logic                     sat;

  logic signed [ACC_W:0]    sum;
  logic                     hi_clip;
  logic                     lo_clip;
  logic                     is_entry;
  logic                     add_ok;
  logic                     row_done;
  logic                     load_bad;
  logic signed [ACC_W-1:0]  acc_next;
  logic                     err_next;
  logic                     sat_next;
  logic [POS_W:0]           row_inc;
  logic [POS_W-1:0]         row_next;

  assign prod = PROD_W'(s1_value) * PROD_W'(rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
    if (adv) begin
      s2_ctrl <= s1_ctrl;
      s2_prod <= prod[PROD_W-1:FRAC_BITS];
    end
  end

  always_comb begin
    sum      = (ACC_W+1)'(acc) + (ACC_W+1)'(s2_prod);
    hi_clip  = !sum[ACC_W] && sum[ACC_W-1];
    lo_clip  = sum[ACC_W] && !sum[ACC_W-1];
    is_entry = (s2_ctrl.req_type == REQ_ENTRY);
    add_ok   = is_entry && s2_ctrl.has_entry && s2_ctrl.pos_ok;
    row_done = is_entry && (s2_ctrl.row_end || !s2_ctrl.has_entry);
    load_bad = !is_entry && !s2_ctrl.pos_ok;

    acc_next = acc;
    if (add_ok) begin
      if (hi_clip) begin
        acc_next = ACC_MAX;
      end else if (lo_clip) begin
        acc_next = ACC_MIN;
      end else begin
        acc_next = sum[ACC_W-1:0];
      end
    end
    sat_next = sat || (add_ok && (hi_clip || lo_clip));
    err_next = err || (is_entry && s2_ctrl.has_entry && !s2_ctrl.pos_ok);

    row_inc  = {1'b0, row} + (POS_W+1)'(1);
    row_next = (32'(row_inc) >= 32'(limit)) ? '0 : row_inc[POS_W-1:0];

    push = adv && s2_valid && (row_done || load_bad);
    if (load_bad) begin
      push_res = '{row_sum: '0, row_number: row, index_error: 1'b1, saturated: 1'b0};
    end else begin
      push_res = '{row_sum: acc_next, row_number: row, index_error: err_next,
                   saturated: sat_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      row <= '0;
      err <= 1'b0;
      sat <= 1'b0;
    end else if (adv && s2_valid && is_entry) begin
      if (row_done) begin
        acc <= '0;
        err <= 1'b0;
        sat <= 1'b0;
        row <= row_next;
      end else begin
        acc <= acc_next;
        err <= err_next;
        sat <= sat_next;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/spmv_oq.sv
// Two-entry result queue decoupling the pipeline from the response channel.
`default_nettype none
module spmv_oq import spmv_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire spmv_res_t push_res,
  output logic           full,
  spmv_rsp_if.source     rsp
);

  spmv_res_t  q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       pop;

  assign pop       = rsp.valid && rsp.ready;
  assign full      = (cnt == 2'd2);
  assign rsp.valid = (cnt != 2'd0);
  assign rsp.row_sum     = q[rp].row_sum;
  assign rsp.row_number  = q[rp].row_number;
  assign rsp.index_error = q[rp].index_error;
  assign rsp.saturated   = q[rp].saturated;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule
`default_nettype wire

### tb/csr_sparse_matrix_vector_multiply_core_tb.sv
// Testbench for the CSR sparse matrix-vector core: vector loads, row streams, lengths, stalls.
`timescale 1ns / 100ps
module csr_sparse_matrix_vector_multiply_core_tb;
  import spmv_pkg::*;

  localparam int     VEC_DEPTH   = 1024;
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     DRAIN_WAIT  = 8;
  localparam int     HOLD_CYCLES = 300;
  localparam longint SUM_HI      = 64'sd140737488355327;
  localparam longint SUM_LO      = -SUM_HI - 1;

  typedef struct packed {
    logic                    req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] entry_value;
    logic                    has_entry;
    logic                    row_end;
  } mv_beat_t;

  logic clk = 1'b0;
  logic rst;

  spmv_req_if req_bus ();
  spmv_cfg_if cfg_bus ();
  spmv_rsp_if rsp_bus ();

  csr_sparse_matrix_vector_multiply_core u_top (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .cfg(cfg_bus),
    .rsp(rsp_bus)
  );

  // Mirror of the block's state
  logic signed [VAL_W-1:0] x_store [VEC_DEPTH];
  bit                      x_loaded [VEC_DEPTH];
  longint                  row_acc;
  logic [POS_W-1:0]        row_idx;
  bit                      row_err;
  bit                      row_sat;
  logic [CFG_W-1:0]        length_reg;
  spmv_res_t               row_results_due [$];

  int mismatches;
  int beats_sent;
  int cycle_count;
  bit idle_on;
  int rsp_hold_requests;
  int rsp_holds_done;
  int rsp_hold_left;
  int rsp_stall_left;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("csr_sparse_matrix_vector_multiply_core_tb: done, errors");
      $finish;
    end
  end

  function automatic int active_len();
    return (length_reg == 0 || length_reg > VEC_DEPTH) ? VEC_DEPTH : int'(length_reg);
  endfunction

  function automatic bit advance_row_product(input mv_beat_t b, output spmv_res_t res);
    int     lim;
    longint sum;
    bit     done;
    lim = active_len();
    res = '0;
    if (b.req_type == REQ_LOAD) begin
      if (b.position < lim) begin
        x_store[b.position]  = b.entry_value;
        x_loaded[b.position] = 1'b1;
        return 1'b0;
      end
      res.row_number  = row_idx;
      res.index_error = 1'b1;
      return 1'b1;
    end
    done = b.row_end;
    if (!b.has_entry) begin
      done = 1'b1;
    end else if (b.position < lim) begin
      sum = row_acc + ((longint'(b.entry_value) * longint'(x_store[b.position])) >>> FRAC_BITS);
      if (sum > SUM_HI) begin
        sum     = SUM_HI;
        row_sat = 1'b1;
      end else if (sum < SUM_LO) begin
        sum     = SUM_LO;
        row_sat = 1'b1;
      end
      row_acc = sum;
    end else begin
      row_err = 1'b1;
    end
    if (!done) return 1'b0;
    res.row_sum     = row_acc[ACC_W-1:0];
    res.row_number  = row_idx;
    res.index_error = row_err;
    res.saturated   = row_sat;
    row_acc = 0;
    row_err = 1'b0;
    row_sat = 1'b0;
    row_idx = (int'(row_idx) + 1 >= lim) ? '0 : row_idx + 1'b1;
    return 1'b1;
  endfunction

  // Receiver: random stall bursts plus long holds on request
  always @(posedge clk) begin
    if (rsp_hold_left > 0) begin
      rsp_hold_left--;
      rsp_bus.ready <= 1'b0;
    end else if (rsp_holds_done != rsp_hold_requests) begin
      rsp_holds_done = rsp_hold_requests;
      rsp_hold_left  = HOLD_CYCLES;
      rsp_bus.ready <= 1'b0;
    end else if (rsp_stall_left > 0) begin
      rsp_stall_left--;
      rsp_bus.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rsp_stall_left = $urandom_range(0, 2);
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    spmv_res_t want;
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (row_results_due.size() == 0) begin
        $error("row result with none due: row_number %0d", rsp_bus.row_number);
        mismatches++;
      end else begin
        want = row_results_due.pop_front();
        check_field("row_sum", longint'($signed(want.row_sum)),
                    longint'($signed(rsp_bus.row_sum)));
        check_field("row_number", want.row_number, rsp_bus.row_number);
        check_field("index_error", want.index_error, rsp_bus.index_error);
        check_field("saturated", want.saturated, rsp_bus.saturated);
      end
    end
  end

  task automatic send_beat(input mv_beat_t b);
    spmv_res_t res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= b.req_type;
    req_bus.position    <= b.position;
    req_bus.entry_value <= b.entry_value;
    req_bus.has_entry   <= b.has_entry;
    req_bus.row_end     <= b.row_end;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    if (advance_row_product(b, res)) row_results_due.insert(row_results_due.size(), res);
    beats_sent++;
  endtask

  function automatic mv_beat_t make_beat(input logic kind, input int pos,
                                         input logic [VAL_W-1:0] val, input logic has,
                                         input logic last);
    mv_beat_t b;
    b.req_type    = kind;
    b.position    = pos[POS_W-1:0];
    b.entry_value = val;
    b.has_entry   = has;
    b.row_end     = last;
    return b;
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3, 4: return $urandom;
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  task automatic load_x(input int pos, input logic [VAL_W-1:0] val);
    send_beat(make_beat(REQ_LOAD, pos, val, 1'($urandom), 1'($urandom)));
  endtask

  task automatic send_entry(input int col, input logic [VAL_W-1:0] val, input logic last);
    send_beat(make_beat(REQ_ENTRY, col, val, 1'b1, last));
  endtask

  task automatic send_marker(input logic last);
    send_beat(make_beat(REQ_ENTRY, $urandom_range(0, VEC_DEPTH - 1), $urandom, 1'b0, last));
  endtask

  // in-range column, loading x first where it has never been written
  task automatic send_good_entry(input logic last);
    int col;
    col = $urandom_range(0, active_len() - 1);
    if (!x_loaded[col]) load_x(col, rand_value());
    send_entry(col, rand_value(), last);
  endtask

  task automatic send_row(input int n);
    if (n == 0) send_marker(1'($urandom));
    for (int k = 0; k < n; k++) begin
      if (active_len() < VEC_DEPTH && $urandom_range(0, 15) == 0)
        send_entry($urandom_range(active_len(), VEC_DEPTH - 1), rand_value(), k == n - 1);
      else
        send_good_entry(k == n - 1);
    end
  endtask

  task automatic send_random_traffic(input int n);
    int stop;
    stop = beats_sent + n;
    while (beats_sent < stop) begin
      case ($urandom_range(0, 9))
        0: load_x($urandom_range(0, active_len() - 1), rand_value());
        1: begin
          if (active_len() < VEC_DEPTH)
            load_x($urandom_range(active_len(), VEC_DEPTH - 1), rand_value());
          else
            load_x($urandom_range(0, VEC_DEPTH - 1), rand_value());
        end
        2: begin
          for (int k = $urandom_range(1, 3); k > 0; k--) send_good_entry(1'b0);
          send_marker(1'($urandom));
        end
        3: send_good_entry(1'($urandom));
        default: send_row($urandom_range(0, 5));
      endcase
    end
  endtask

  task automatic write_length(input logic [CFG_W-1:0] len);
    req_bus.valid <= 1'b0;
    while (row_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_bus.valid         <= 1'b1;
    cfg_bus.vector_length <= len;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    length_reg = len;
  endtask

  task automatic test_directed();
    load_x(0, 32'h7FFF_FFFF);
    load_x(1, 32'h8000_0000);
    load_x(2, 32'h0000_0001);
    load_x(512, 32'hFFFF_0000);
    load_x(1023, 32'h0001_0000);
    send_entry(1023, 32'h0002_0000, 1'b1);
    send_entry(0, 32'h7FFF_FFFF, 1'b0);
    send_entry(512, 32'h8000_0000, 1'b1);
    // clip at the top, then at the bottom
    repeat (2) send_entry(1, 32'h8000_0000, 1'b0);
    send_entry(1, 32'h8000_0000, 1'b1);
    repeat (2) send_entry(1, 32'h7FFF_FFFF, 1'b0);
    send_entry(1, 32'h7FFF_FFFF, 1'b1);
    // negative lsb product rounds down
    send_entry(2, 32'hFFFF_FFFF, 1'b1);
    send_marker(1'b0);
    send_entry(2, 32'h0000_0003, 1'b0);
    send_marker(1'b0);
    write_length(11'd4);
    load_x(4, 32'h1234_5678);
    load_x(1023, 32'h0000_0000);
    send_entry(700, 32'h0001_0000, 1'b0);
    send_entry(0, 32'h0001_0000, 1'b1);
    repeat (4) send_entry(2, 32'h0003_0000, 1'b1);
    write_length(11'd1);
    load_x(0, 32'hFFFF_FFFF);
    send_entry(0, 32'h8000_0000, 1'b1);
    send_entry(1, 32'h0001_0000, 1'b1);
  endtask

  task automatic test_length_sweep();
    logic [CFG_W-1:0] lengths [7];
    lengths = '{11'd0, 11'd2047, 11'd1, 11'd2, 11'd1025, 11'd1024, 11'd0};
    lengths[6] = 11'($urandom_range(3, 1023));
    foreach (lengths[i]) begin
      write_length(lengths[i]);
      send_random_traffic(50);
    end
  endtask

  // results back up behind a long receiver hold; req must stall
  task automatic test_backpressure();
    write_length(11'd16);
    rsp_hold_requests++;
    for (int k = 0; k < 60; k++) send_good_entry(1'b1);
  endtask

  task automatic test_random();
    for (int p = 0; p < 4; p++) begin
      write_length(p == 0 ? 11'd1024 : 11'($urandom_range(1, 1024)));
      send_random_traffic(250);
    end
    idle_on = 1'b0;
    write_length(11'd1024);
    send_random_traffic(200);
  endtask

  initial begin
    rst                   = 1'b1;
    req_bus.valid         = 1'b0;
    req_bus.req_type      = REQ_LOAD;
    req_bus.position      = '0;
    req_bus.entry_value   = '0;
    req_bus.has_entry     = 1'b0;
    req_bus.row_end       = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.vector_length = '0;
    rsp_bus.ready         = 1'b0;
    row_acc               = 0;
    row_idx               = '0;
    row_err               = 1'b0;
    row_sat               = 1'b0;
    length_reg            = 11'd1024;
    idle_on               = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_length_sweep();
    test_backpressure();
    test_random();
    req_bus.valid <= 1'b0;
    while (row_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("csr_sparse_matrix_vector_multiply_core_tb: done, clean");
    end else begin
      $display("csr_sparse_matrix_vector_multiply_core_tb: done, errors");
    end
    $finish;
  end

endmodule
